// ----- rtl/tea_pkg.sv -----
`timescale 1ns / 1ps

package tea_pkg;

  // field widths
  localparam int OP_W       = 3;
  localparam int RAW_W      = 12;
  localparam int RES_W      = 10;
  localparam int POS_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // significant raw bits and the edge margin in pixels
  localparam int RAW_BITS    = 12;
  localparam int EDGE_MARGIN = 15;
  localparam logic [RAW_W-1:0] RAW_MASK =
    (RAW_BITS >= RAW_W) ? {RAW_W{1'b1}} : RAW_W'((1 << RAW_BITS) - 1);

  // datapath widths: signed difference, signed factor, product, magnitudes
  localparam int DIFF_W = RAW_W + 1;
  localparam int FAC_W  = RES_W + 1;
  localparam int NUM_W  = DIFF_W + FAC_W;
  localparam int MAG_W  = NUM_W - 1;
  localparam int DEN_W  = RAW_W;

  // event queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // event codes on the input
  localparam logic [OP_W-1:0] OP_X_SAMPLE = 3'd0;
  localparam logic [OP_W-1:0] OP_Y_SAMPLE = 3'd1;
  localparam logic [OP_W-1:0] OP_DOWN     = 3'd2;
  localparam logic [OP_W-1:0] OP_UP       = 3'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_RES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_RES = 3'd5;

  typedef enum logic [1:0] {
    KIND_X,
    KIND_Y,
    KIND_DOWN,
    KIND_UP
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [RAW_W-1:0] raw;
  } cmd_t;

  typedef struct packed {
    logic [RAW_W-1:0] x_min;
    logic [RAW_W-1:0] x_max;
    logic [RAW_W-1:0] y_min;
    logic [RAW_W-1:0] y_max;
    logic [RES_W-1:0] x_res;
    logic [RES_W-1:0] y_res;
  } cal_t;

  function automatic logic [RAW_W-1:0] mask_raw(input logic [RAW_W-1:0] v);
    return v & RAW_MASK;
  endfunction

endpackage

// ----- rtl/tea_front.sv -----
`timescale 1ns / 1ps

module tea_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [tea_pkg::OP_W-1:0] in_op,
  input  logic [tea_pkg::RAW_W-1:0] in_raw,
  output logic                     cmd_valid,
  output tea_pkg::cmd_t            cmd,
  input  logic                     cmd_pop
);
  import tea_pkg::*;

  cmd_t              queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              keep;
  kind_t             kind;
  logic              push;
  logic              pop;

  // classify the event; unknown kinds are taken and dropped
  always_comb begin
    keep = 1'b1;
    kind = KIND_X;
    unique case (in_op)
      OP_X_SAMPLE: kind = KIND_X;
      OP_Y_SAMPLE: kind = KIND_Y;
      OP_DOWN:     kind = KIND_DOWN;
      OP_UP:       kind = KIND_UP;
      default:     keep = 1'b0;
    endcase
  end

  assign in_tready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready && keep;
  assign cmd_valid = (count_r != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = queue_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= '{kind: kind, raw: in_raw};
    end
  end

endmodule

// ----- rtl/tea_div.sv -----
`timescale 1ns / 1ps

module tea_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tea_pkg::MAG_W-1:0] dividend,
  input  logic [tea_pkg::DEN_W-1:0] divisor,
  output logic                      done,
  output logic [tea_pkg::MAG_W-1:0] quotient
);
  import tea_pkg::*;

  localparam int CNT_W = $clog2(MAG_W);

  logic [DEN_W-1:0] rem_r;
  logic [MAG_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             fits;

  // one restoring step: shift in the next dividend bit, try a subtract
  assign shifted = {rem_r, quo_r[MAG_W-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign fits    = !trial[DEN_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_r <= {quo_r[MAG_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/tea_back.sv -----
`timescale 1ns / 1ps

module tea_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_valid,
  input  tea_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  input  tea_pkg::cal_t             cal,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [tea_pkg::POS_W-1:0] out_pos_x,
  output logic [tea_pkg::POS_W-1:0] out_pos_y,
  output logic                      out_pressed
);
  import tea_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DSTART = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0]              state_r;
  logic [RES_W-1:0]        held_x_r, held_y_r;
  logic                    held_x_valid_r, held_y_valid_r;
  logic                    touch_r;
  logic                    axis_y_r;
  logic [RAW_W-1:0]        raw_r;
  logic signed [NUM_W-1:0] num_r;
  logic signed [DIFF_W-1:0] span_r;
  logic                    neg_r;
  logic                    zero_r;
  logic                    emit_press_r;
  logic                    out_valid_r;
  logic [POS_W-1:0]        out_x_r, out_y_r;
  logic                    out_press_r;

  logic [RAW_W-1:0]         lo, hi;
  logic [RES_W-1:0]         res;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] span;
  logic signed [FAC_W-1:0]  fac;
  logic signed [NUM_W-1:0]  prod;
  logic [NUM_W-1:0]         num_abs;
  logic [DIFF_W-1:0]        span_abs;
  logic                     div_start;
  logic                     div_done;
  logic [MAG_W-1:0]         div_quo;
  logic signed [NUM_W-1:0]  quo_s;
  logic signed [NUM_W:0]    v;
  logic [RES_W-1:0]         v_clamp;
  logic [RES_W-1:0]         pix;
  logic                     slot_free;

  // calibration for the axis at work
  always_comb begin
    lo  = mask_raw(axis_y_r ? cal.y_min : cal.x_min);
    hi  = mask_raw(axis_y_r ? cal.y_max : cal.x_max);
    res = axis_y_r ? cal.y_res : cal.x_res;
  end

  // numerator product and span
  always_comb begin
    diff = $signed({1'b0, mask_raw(raw_r)}) - $signed({1'b0, lo});
    span = $signed({1'b0, hi}) - $signed({1'b0, lo});
    fac  = $signed({1'b0, res}) - $signed(FAC_W'(2 * EDGE_MARGIN));
    prod = NUM_W'(diff) * NUM_W'(fac);
  end

  // magnitudes for the unsigned divider
  assign num_abs  = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign span_abs = span_r[DIFF_W-1] ? DIFF_W'(-span_r) : DIFF_W'(span_r);
  assign div_start = (state_r == ST_DSTART);

  tea_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_abs[MAG_W-1:0]),
    .divisor  (span_abs[DEN_W-1:0]),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sign, margin, clamp to 0..res and mirror
  always_comb begin
    if (zero_r) begin
      quo_s = '0;
    end else if (neg_r) begin
      quo_s = -$signed({1'b0, div_quo});
    end else begin
      quo_s = $signed({1'b0, div_quo});
    end
    v = (NUM_W + 1)'(quo_s) + $signed((NUM_W + 1)'(EDGE_MARGIN));
    if (v < 0) begin
      v_clamp = '0;
    end else if (v > $signed({{(NUM_W + 1 - RES_W){1'b0}}, res})) begin
      v_clamp = res;
    end else begin
      v_clamp = v[RES_W-1:0];
    end
    pix = res - v_clamp;
  end

  assign slot_free = !out_valid_r || out_ready;
  assign cmd_pop   = (state_r == ST_IDLE) && cmd_valid;

  // event sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      held_x_valid_r <= 1'b0;
      held_y_valid_r <= 1'b0;
      touch_r        <= 1'b0;
      out_valid_r    <= 1'b0;
      held_x_r       <= '0;
      held_y_r       <= '0;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.kind)
              KIND_X, KIND_Y: begin
                axis_y_r <= (cmd.kind == KIND_Y);
                raw_r    <= cmd.raw;
                state_r  <= ST_MUL;
              end
              KIND_DOWN: begin
                touch_r        <= 1'b1;
                held_x_r       <= '0;
                held_y_r       <= '0;
                held_x_valid_r <= 1'b0;
                held_y_valid_r <= 1'b0;
              end
              KIND_UP: begin
                emit_press_r <= 1'b0;
                state_r      <= ST_EMIT;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_MUL: begin
          num_r   <= prod;
          span_r  <= span;
          state_r <= ST_DSTART;
        end
        ST_DSTART: begin
          neg_r   <= num_r[NUM_W-1] ^ span_r[DIFF_W-1];
          zero_r  <= (span_r == '0);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          emit_press_r <= touch_r;
          if (axis_y_r) begin
            held_y_r       <= pix;
            held_y_valid_r <= 1'b1;
            state_r        <= held_x_valid_r ? ST_EMIT : ST_IDLE;
          end else begin
            held_x_r       <= pix;
            held_x_valid_r <= 1'b1;
            state_r        <= held_y_valid_r ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_r    <= 1'b1;
            held_x_r       <= '0;
            held_y_r       <= '0;
            held_x_valid_r <= 1'b0;
            held_y_valid_r <= 1'b0;
            touch_r        <= 1'b0;
            state_r        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // report payload, -1 for a missing axis
  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && slot_free) begin
      out_x_r     <= held_x_valid_r ? {1'b0, held_x_r} : {POS_W{1'b1}};
      out_y_r     <= held_y_valid_r ? {1'b0, held_y_r} : {POS_W{1'b1}};
      out_press_r <= emit_press_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pos_x   = out_x_r;
  assign out_pos_y   = out_y_r;
  assign out_pressed = out_press_r;

endmodule

// ----- rtl/touch_event_assembler_scaler_top.sv -----
`timescale 1ns / 1ps

// channel   direction  payload
// in_       slave      tuser: op[2:0]; tdata: sample_value[11:0], zero fill to 16
// out_      master     tdata: pos_x[10:0], pos_y[21:11], zero fill to 24; tuser: pressed
// cfg_      slave      index[2:0], data[11:0]; always ready
//
// an X or Y sample holds the back end through pop, multiply, divider load, 23 one-bit
// divider steps, the wait for divider done and finish; a report adds the emit state.
// touch down stays in idle, touch up visits emit; ignored events never enter the queue.
// a two-entry event queue lets input transfers continue while the back end works.
// a report waits in the output register under back pressure, holding the back end.
// rst_n is synchronous; no clearing pass is needed, state is ready after reset.

module touch_event_assembler_scaler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample_value[11:0], zero [15:12]
  input  logic [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pos_x[10:0], pos_y[21:11], zero [23:22]
  output logic        out_tuser,  // pressed
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import tea_pkg::*;

  cal_t             cal_r;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;
  logic [POS_W-1:0] pos_x, pos_y;
  logic             pressed;

  // calibration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r.x_min <= RAW_W'(0);
      cal_r.x_max <= RAW_W'(1023);
      cal_r.y_min <= RAW_W'(0);
      cal_r.y_max <= RAW_W'(1023);
      cal_r.x_res <= RES_W'(480);
      cal_r.y_res <= RES_W'(272);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_X_MIN: cal_r.x_min <= cfg_data[RAW_W-1:0];
        CFG_X_MAX: cal_r.x_max <= cfg_data[RAW_W-1:0];
        CFG_Y_MIN: cal_r.y_min <= cfg_data[RAW_W-1:0];
        CFG_Y_MAX: cal_r.y_max <= cfg_data[RAW_W-1:0];
        CFG_X_RES: cal_r.x_res <= cfg_data[RES_W-1:0];
        CFG_Y_RES: cal_r.y_res <= cfg_data[RES_W-1:0];
        default:   cal_r <= cal_r;
      endcase
    end
  end

  tea_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .in_raw    (in_tdata[RAW_W-1:0]),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tea_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .cal         (cal_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_pos_x   (pos_x),
    .out_pos_y   (pos_y),
    .out_pressed (pressed)
  );

  assign out_tdata = {2'b00, pos_y, pos_x};
  assign out_tuser = pressed;

`ifndef SYNTHESIS
  // a pressed report comes only from axis completion, so both axes are present
  a_pressed_has_axes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (!out_tdata[10] && !out_tdata[21]))
    else $error("pressed report with a missing axis");

  // a present X position never exceeds the screen width
  a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[10]) |-> (out_tdata[9:0] <= cal_r.x_res))
    else $error("X position beyond screen width");

  // no report is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("report offered after reset");
`endif

endmodule

// ----- dv/tb_touch_event_assembler_scaler_top.sv -----
`timescale 1ns / 1ps

module tb_touch_event_assembler_scaler_top;
  import tea_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 150;

  // event codes the block drops without a trace
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd4;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  // axis code reported when that axis was never sampled
  localparam logic [POS_W-1:0] NO_AXIS = '1;

  localparam cal_t CAL_RESET = '{
    x_min: 12'd0, x_max: 12'd1023, y_min: 12'd0, y_max: 12'd1023,
    x_res: 10'd480, y_res: 10'd272
  };

  typedef struct {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             pressed;
  } touch_report_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [11:0] cfg_data   = '0;

  // predicted block state
  cal_t             cal_now     = CAL_RESET;
  logic [RES_W-1:0] pend_x      = '0;
  logic [RES_W-1:0] pend_y      = '0;
  logic             pend_x_ok   = 1'b0;
  logic             pend_y_ok   = 1'b0;
  logic             touch_seen  = 1'b0;
  touch_report_t    pending_reports[$];

  int          mismatch_count = 0;
  int          events_sent    = 0;
  int          tx_gap_max     = 9;
  int          rx_gap_max     = 9;
  bit          rx_stall       = 1'b0;
  int unsigned cycle_count    = 0;

  touch_event_assembler_scaler_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // linear calibration, clamp to the screen, then mirror
  function automatic logic [RES_W-1:0] scale_axis(input logic [RAW_W-1:0] raw,
                                                  input logic [RAW_W-1:0] lo,
                                                  input logic [RAW_W-1:0] hi,
                                                  input logic [RES_W-1:0] res);
    longint offs, span, prod, quo, pix, res_l;
    res_l = longint'(res);
    offs  = longint'(raw & RAW_MASK) - longint'(lo & RAW_MASK);
    span  = longint'(hi & RAW_MASK) - longint'(lo & RAW_MASK);
    prod  = offs * (res_l - 2 * EDGE_MARGIN);
    // signed division truncates toward zero; a flat span gives zero
    quo   = (span != 0) ? prod / span : 0;
    pix   = quo + EDGE_MARGIN;
    if (pix < 0) pix = 0;
    else if (pix > res_l) pix = res_l;
    return RES_W'(res_l - pix);
  endfunction

  // every report empties the held axes and the touch flag
  function automatic void queue_report(input logic pressed);
    touch_report_t r;
    r.pos_x   = pend_x_ok ? POS_W'(pend_x) : NO_AXIS;
    r.pos_y   = pend_y_ok ? POS_W'(pend_y) : NO_AXIS;
    r.pressed = pressed;
    pending_reports.push_back(r);
    pend_x     = '0;
    pend_y     = '0;
    pend_x_ok  = 1'b0;
    pend_y_ok  = 1'b0;
    touch_seen = 1'b0;
  endfunction

  function automatic void track_event(input logic [OP_W-1:0] op,
                                      input logic [RAW_W-1:0] smp);
    case (op)
      OP_X_SAMPLE: begin
        pend_x    = scale_axis(smp, cal_now.x_min, cal_now.x_max, cal_now.x_res);
        pend_x_ok = 1'b1;
        if (pend_y_ok) queue_report(touch_seen);
      end
      OP_Y_SAMPLE: begin
        pend_y    = scale_axis(smp, cal_now.y_min, cal_now.y_max, cal_now.y_res);
        pend_y_ok = 1'b1;
        if (pend_x_ok) queue_report(touch_seen);
      end
      OP_DOWN: begin
        touch_seen = 1'b1;
        pend_x     = '0;
        pend_y     = '0;
        pend_x_ok  = 1'b0;
        pend_y_ok  = 1'b0;
      end
      OP_UP: queue_report(1'b0);
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // one event transfer after a random gap; tvalid stays up for the next call
  task automatic send_event(input logic [OP_W-1:0] op, input logic [RAW_W-1:0] smp);
    int gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= 16'(smp);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_event(op, smp);
    if (op <= OP_UP) events_sent++;
  endtask

  // wait out every expected report and any silent work behind it
  task automatic drain_reports();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_cal(input cal_t c);
    write_reg(CFG_X_MIN, c.x_min);
    write_reg(CFG_X_MAX, c.x_max);
    write_reg(CFG_Y_MIN, c.y_min);
    write_reg(CFG_Y_MAX, c.y_max);
    write_reg(CFG_X_RES, CFG_DATA_W'(c.x_res));
    write_reg(CFG_Y_RES, CFG_DATA_W'(c.y_res));
    cfg_valid <= 1'b0;
    cal_now = c;
  endtask

  // raw readings lean on the rails now and then
  function automatic logic [RAW_W-1:0] rand_sample();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return '1;
      default: return RAW_W'($urandom_range(4095, 0));
    endcase
  endfunction

  function automatic logic [RES_W-1:0] rand_res();
    case ($urandom_range(5, 0))
      0: return RES_W'(31);
      1: return RES_W'(1023);
      default: return RES_W'($urandom_range(1023, 31));
    endcase
  endfunction

  function automatic cal_t rand_cal();
    cal_t c;
    c.x_min = rand_sample();
    c.x_max = rand_sample();
    c.y_min = rand_sample();
    c.y_max = rand_sample();
    if ($urandom_range(6, 0) == 0) c.x_max = c.x_min;
    if ($urandom_range(6, 0) == 0) c.y_max = c.y_min;
    c.x_res = rand_res();
    c.y_res = rand_res();
    return c;
  endfunction

  // one press with both axes, mostly complete, sometimes cut short or disturbed
  task automatic send_gesture();
    logic [OP_W-1:0] first_axis, other_axis;
    int shape;
    first_axis = ($urandom_range(1, 0) == 0) ? OP_X_SAMPLE : OP_Y_SAMPLE;
    other_axis = (first_axis == OP_X_SAMPLE) ? OP_Y_SAMPLE : OP_X_SAMPLE;
    shape      = $urandom_range(9, 0);
    if ($urandom_range(4, 0) != 0) send_event(OP_DOWN, rand_sample());
    send_event(first_axis, rand_sample());
    case (shape)
      6: begin
        send_event(first_axis, rand_sample());
        send_event(other_axis, rand_sample());
      end
      7: send_event(OP_UP, rand_sample());
      8: begin
        send_event(OP_DOWN, rand_sample());
        send_event(other_axis, rand_sample());
        send_event(OP_UP, rand_sample());
      end
      9: begin
        send_event(OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), rand_sample());
        send_event(other_axis, rand_sample());
      end
      default: send_event(other_axis, rand_sample());
    endcase
  endtask

  task automatic test_reset_calibration();
    // pressed pair at the raw rails
    send_event(OP_DOWN, '0);
    send_event(OP_X_SAMPLE, '0);
    send_event(OP_Y_SAMPLE, '1);
    // lift with nothing held
    send_event(OP_UP, '0);
    // lift with a single axis
    send_event(OP_X_SAMPLE, 12'd1023);
    send_event(OP_UP, '1);
    send_event(OP_Y_SAMPLE, 12'd2048);
    send_event(OP_UP, '0);
    // spare codes leave the state alone
    for (int k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
      send_event(OP_W'(k), '1);
    // a repeated axis replaces the held one
    send_event(OP_X_SAMPLE, 12'd100);
    send_event(OP_X_SAMPLE, 12'd900);
    send_event(OP_Y_SAMPLE, 12'd500);
    // touch down drops a held axis, lift still reports unpressed
    send_event(OP_X_SAMPLE, 12'd700);
    send_event(OP_DOWN, '0);
    send_event(OP_Y_SAMPLE, 12'd300);
    send_event(OP_UP, '0);
    drain_reports();
  endtask

  task automatic test_zero_and_reversed_span();
    cal_t c;
    c.x_min = 12'd2000;
    c.x_max = 12'd2000;
    c.y_min = 12'd4000;
    c.y_max = 12'd100;
    c.x_res = RES_W'(31);
    c.y_res = RES_W'(1023);
    write_cal(c);
    send_event(OP_X_SAMPLE, '0);
    send_event(OP_Y_SAMPLE, '0);
    send_event(OP_Y_SAMPLE, '1);
    send_event(OP_X_SAMPLE, '1);
    drain_reports();
  endtask

  task automatic test_extreme_calibration();
    cal_t c;
    c.x_min = '1;
    c.x_max = '0;
    c.y_min = '0;
    c.y_max = '1;
    c.x_res = RES_W'(1023);
    c.y_res = RES_W'(31);
    write_cal(c);
    send_event(OP_X_SAMPLE, '1);
    send_event(OP_Y_SAMPLE, '0);
    send_event(OP_Y_SAMPLE, '1);
    send_event(OP_X_SAMPLE, '0);
    drain_reports();
  endtask

  // receiver holds off while events keep coming, so the input side backs up
  task automatic test_output_backpressure();
    write_cal(rand_cal());
    tx_gap_max = 0;
    fork
      begin
        rx_stall <= 1'b1;
        repeat (400) @(posedge clk);
        rx_stall <= 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++) send_gesture();
      end
    join
    tx_gap_max = 9;
    drain_reports();
  endtask

  task automatic test_random_gestures();
    int target;
    for (int phase = 0; phase < 4; phase++) begin
      write_cal(rand_cal());
      // one phase runs with no idling on either side
      tx_gap_max = (phase == 1) ? 0 : 9;
      rx_gap_max <= (phase == 1) ? 0 : 9;
      target = events_sent + 75;
      while (events_sent < target) begin
        if ($urandom_range(9, 0) < 7)
          send_gesture();
        else
          send_event(OP_W'($urandom_range(OP_SPARE_LAST, 0)), RAW_W'($urandom_range(4095, 0)));
      end
      drain_reports();
    end
    rx_gap_max <= 9;
  endtask

  // receiver ready with a random pause after each transfer
  always @(posedge clk) begin : drive_out_ready
    int hold;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold = 0;
    end else if (rx_stall) begin
      out_tready <= 1'b0;
    end else if (out_tready) begin
      if (out_tvalid) begin
        hold = $urandom_range(rx_gap_max, 0);
        if (hold != 0) begin
          out_tready <= 1'b0;
          hold = hold - 1;
        end
      end
    end else if (hold != 0) begin
      hold = hold - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each report transfer with the oldest prediction
  always @(posedge clk) begin : check_reports
    touch_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("report with none expected, pos_x",
                        int'($signed(out_tdata[POS_W-1:0])), 0);
      end else begin
        want = pending_reports.pop_front();
        if (out_tdata[POS_W-1:0] !== want.pos_x)
          report_mismatch("pos_x", int'($signed(out_tdata[POS_W-1:0])),
                          int'($signed(want.pos_x)));
        if (out_tdata[2*POS_W-1:POS_W] !== want.pos_y)
          report_mismatch("pos_y", int'($signed(out_tdata[2*POS_W-1:POS_W])),
                          int'($signed(want.pos_y)));
        if (out_tuser !== want.pressed)
          report_mismatch("pressed", int'(out_tuser), int'(want.pressed));
      end
    end
  end

  // overall time limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("touch_event_assembler_scaler_top test failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_calibration();
    test_zero_and_reversed_span();
    test_extreme_calibration();
    test_output_backpressure();
    test_random_gestures();
    drain_reports();
    if (mismatch_count == 0)
      $display("touch_event_assembler_scaler_top test passed");
    else
      $display("touch_event_assembler_scaler_top test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tea_pkg.sv
rtl/tea_front.sv
rtl/tea_div.sv
rtl/tea_back.sv
rtl/touch_event_assembler_scaler_top.sv
dv/tb_touch_event_assembler_scaler_top.sv
